### rtl/bsa_pkg.sv
// Shared types and constants for the banker's safety allocator.
// Used by bsa_ctrl, bsa_datapath and bankers_safety_allocator; no dependencies.
package bsa_pkg;

   localparam int MAX_PROCESSES = 8;
   localparam int RESOURCES     = 4;
   localparam int COUNT_WIDTH   = 8;

   localparam int PID_W  = $clog2(MAX_PROCESSES);
   localparam int N_W    = $clog2(MAX_PROCESSES + 1);
   localparam int USED_W = COUNT_WIDTH + $clog2(MAX_PROCESSES);
   localparam int WORK_W = USED_W + 1;

   localparam logic [2:0] CSR_PROCESS_COUNT = 3'd0;
   localparam logic [2:0] CSR_TOTAL_BASE    = 3'd1;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef count_type [RESOURCES-1:0] vec_type;

   typedef enum logic [2:0] {
      KIND_NOP         = 3'd0,
      KIND_CLAIM       = 3'd1,
      KIND_REQUEST     = 3'd2,
      KIND_RELEASE     = 3'd3,
      KIND_RELEASE_ALL = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      STS_APPROVED     = 3'd0,
      STS_WAIT         = 3'd1,
      STS_UNSAFE       = 3'd2,
      STS_OVER_CLAIM   = 3'd3,
      STS_OVER_RELEASE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic step;
   } dp_cmd_type;

   typedef struct packed {
      logic go_scan;
      logic scan_end;
   } dp_sts_type;

endpackage

### rtl/bsa_ctrl.sv
// Sequencer for the banker's safety allocator.
// Depends on bsa_pkg; drives the bsa_datapath command struct.
module bsa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  bsa_pkg::dp_sts_type sts,
   output bsa_pkg::dp_cmd_type cmd,
   output logic               busy
);

   bsa_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         bsa_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = bsa_pkg::ST_CHECK;
            end
         end
         bsa_pkg::ST_CHECK: begin
            cmd.eval = 1'b1;
            state_in = sts.go_scan ? bsa_pkg::ST_SCAN : bsa_pkg::ST_IDLE;
         end
         bsa_pkg::ST_SCAN: begin
            cmd.step = 1'b1;
            if (sts.scan_end) begin
               state_in = bsa_pkg::ST_IDLE;
            end
         end
         default: state_in = bsa_pkg::ST_IDLE;
      endcase
   end

   assign busy = (state_ff != bsa_pkg::ST_IDLE);

endmodule

### rtl/bsa_datapath.sv
// Tables, checks and safety scan of the banker's safety allocator.
// Depends on bsa_pkg; commanded by bsa_ctrl.
module bsa_datapath (
   input  logic                clock,
   input  logic                reset,
   input  bsa_pkg::dp_cmd_type  cmd,
   output bsa_pkg::dp_sts_type  sts,
   input  logic [2:0]          req_kind,
   input  logic [2:0]          req_process_id,
   input  bsa_pkg::vec_type     req_amount,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status
);

   localparam int PW = bsa_pkg::PID_W;
   localparam int NW = bsa_pkg::N_W;
   localparam int CW = bsa_pkg::COUNT_WIDTH;
   localparam int UW = bsa_pkg::USED_W;
   localparam int WW = bsa_pkg::WORK_W;
   localparam int NR = bsa_pkg::RESOURCES;
   localparam int NP = bsa_pkg::MAX_PROCESSES;

   bsa_pkg::vec_type max_ff   [NP];
   bsa_pkg::vec_type alloc_ff [NP];
   bsa_pkg::vec_type free_ff;
   bsa_pkg::vec_type total_ff;
   logic [NR-1:0][UW-1:0] used_ff;
   logic [WW-1:0] work_ff [NR];
   logic [3:0]    pcount_ff;
   logic [2:0]    kind_ff;
   logic [PW-1:0] pid_ff;
   bsa_pkg::vec_type amt_ff;
   logic [NW-1:0] n_ff;
   logic [PW-1:0] idx_ff;
   logic [NP-1:0] done_ff;
   logic [NW-1:0] fin_ff;
   logic          prog_ff;
   logic [2:0]    status_ff;
   logic          rsp_valid_ff;

   logic [PW-1:0]    row;
   bsa_pkg::vec_type mrow, arow;
   logic inactive, claim_err, over, short, rel_err, fits, take, last, all_done;
   logic [NW-1:0] fin_nx;
   logic          prog_nx;
   logic [NW-1:0] n_load;
   logic [CW:0]   a_sum [NR];
   logic [CW:0]   need  [NR];
   logic [CW-1:0] rneed [NR];

   function automatic logic req_kind_is_request(input logic [2:0] k);
      return k == bsa_pkg::KIND_REQUEST;
   endfunction

   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CW] ? {CW{1'b1}} : s[CW-1:0];
   endfunction

   always_comb begin
      row = cmd.step ? idx_ff : pid_ff;
      mrow = max_ff[row];
      arow = alloc_ff[row];
      inactive  = ({{(NW-PW){1'b0}}, pid_ff} >= n_ff);
      claim_err = 1'b0;
      over      = 1'b0;
      short     = 1'b0;
      rel_err   = 1'b0;
      fits      = 1'b1;
      for (int r = 0; r < NR; r++) begin
         rneed[r] = (mrow[r] > arow[r]) ? mrow[r] - arow[r] : '0;
         if (amt_ff[r] > total_ff[r] || amt_ff[r] < arow[r]) claim_err = 1'b1;
         if (amt_ff[r] > rneed[r]) over = 1'b1;
         if (amt_ff[r] > free_ff[r]) short = 1'b1;
         if (amt_ff[r] > arow[r]) rel_err = 1'b1;
         a_sum[r] = {1'b0, arow[r]} + ((idx_ff == pid_ff) ? {1'b0, amt_ff[r]} : '0);
         need[r]  = ({1'b0, mrow[r]} > a_sum[r]) ? {1'b0, mrow[r]} - a_sum[r] : '0;
         if (WW'(need[r]) > work_ff[r]) fits = 1'b0;
      end
      take     = !done_ff[idx_ff] && fits;
      fin_nx   = fin_ff + NW'(take);
      prog_nx  = prog_ff | take;
      last     = ({{(NW-PW){1'b0}}, idx_ff} == n_ff - NW'(1));
      all_done = (fin_nx == n_ff);
      sts.go_scan  = cmd.eval && (req_kind_is_request(kind_ff)) && !inactive && !over && !short;
      sts.scan_end = cmd.step && (all_done || (last && !prog_nx));
      if (pcount_ff == '0) begin
         n_load = NW'(1);
      end else if (NW'(pcount_ff) > NW'(NP)) begin
         n_load = NW'(NP);
      end else begin
         n_load = NW'(pcount_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff    <= 4'(NP);
         total_ff     <= '0;
         free_ff      <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= bsa_pkg::STS_APPROVED;
         for (int p = 0; p < NP; p++) begin
            max_ff[p]   <= '0;
            alloc_ff[p] <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            if (csr_index == bsa_pkg::CSR_PROCESS_COUNT) begin
               pcount_ff <= csr_wdata[3:0];
            end else begin
               for (int r = 0; r < NR; r++) begin
                  if (csr_index == bsa_pkg::CSR_TOTAL_BASE + 3'(r)) begin
                     total_ff[r] <= csr_wdata[CW-1:0];
                     free_ff[r]  <= (UW'(csr_wdata) > used_ff[r])
                                    ? CW'(UW'(csr_wdata) - used_ff[r]) : '0;
                  end
               end
            end
         end
         if (cmd.load) begin
            kind_ff <= req_kind;
            pid_ff  <= req_process_id;
            amt_ff  <= req_amount;
            n_ff    <= n_load;
         end
         if (cmd.eval) begin
            rsp_valid_ff <= !sts.go_scan;
            status_ff    <= bsa_pkg::STS_APPROVED;
            idx_ff       <= '0;
            done_ff      <= '0;
            fin_ff       <= '0;
            prog_ff      <= 1'b0;
            for (int r = 0; r < NR; r++) begin
               work_ff[r] <= WW'(free_ff[r] - amt_ff[r]);
            end
            if (!inactive) begin
               unique case (kind_ff)
                  bsa_pkg::KIND_CLAIM: begin
                     if (claim_err) begin
                        status_ff <= bsa_pkg::STS_OVER_CLAIM;
                     end else begin
                        max_ff[pid_ff] <= amt_ff;
                     end
                  end
                  bsa_pkg::KIND_REQUEST: begin
                     if (over) begin
                        status_ff <= bsa_pkg::STS_OVER_CLAIM;
                     end else if (short) begin
                        status_ff <= bsa_pkg::STS_WAIT;
                     end
                  end
                  bsa_pkg::KIND_RELEASE: begin
                     if (rel_err) begin
                        status_ff <= bsa_pkg::STS_OVER_RELEASE;
                     end else begin
                        for (int r = 0; r < NR; r++) begin
                           alloc_ff[pid_ff][r] <= arow[r] - amt_ff[r];
                           free_ff[r] <= sat_add(free_ff[r], amt_ff[r]);
                           used_ff[r] <= used_ff[r] - UW'(amt_ff[r]);
                        end
                     end
                  end
                  bsa_pkg::KIND_RELEASE_ALL: begin
                     for (int r = 0; r < NR; r++) begin
                        alloc_ff[pid_ff][r] <= '0;
                        free_ff[r] <= sat_add(free_ff[r], arow[r]);
                        used_ff[r] <= used_ff[r] - UW'(arow[r]);
                     end
                  end
                  default: ;
               endcase
            end
         end
         if (cmd.step) begin
            fin_ff  <= fin_nx;
            prog_ff <= prog_nx;
            if (take) begin
               done_ff[idx_ff] <= 1'b1;
               for (int r = 0; r < NR; r++) begin
                  work_ff[r] <= work_ff[r] + WW'(a_sum[r]);
               end
            end
            if (sts.scan_end) begin
               rsp_valid_ff <= 1'b1;
               if (all_done) begin
                  status_ff <= bsa_pkg::STS_APPROVED;
                  for (int r = 0; r < NR; r++) begin
                     alloc_ff[pid_ff][r] <= alloc_ff[pid_ff][r] + amt_ff[r];
                     free_ff[r] <= free_ff[r] - amt_ff[r];
                     used_ff[r] <= used_ff[r] + UW'(amt_ff[r]);
                  end
               end else begin
                  status_ff <= bsa_pkg::STS_UNSAFE;
               end
            end else if (last) begin
               idx_ff  <= '0;
               prog_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + PW'(1);
            end
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;

endmodule

### rtl/bankers_safety_allocator.sv
// A transaction is accepted when start is high and busy is low. Claims,
// releases, no-ops and rejected requests answer from the check state; the result
// is registered as that state ends. A request that reaches the safety check answers
// when the scan, which compares one process per cycle, ends.
// One transaction at a time; the result strobe cannot be stalled.
// Reset (synchronous, active high): empty tables, no free instances, process count 8.
module bankers_safety_allocator (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_kind,
   input  logic [2:0] req_process_id,
   input  logic [7:0] req_amount_0,
   input  logic [7:0] req_amount_1,
   input  logic [7:0] req_amount_2,
   input  logic [7:0] req_amount_3,
   output logic       rsp_valid,
   output logic [2:0] rsp_status,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   // The controller sequences check, scan and response; the datapath holds
   // every table and does all arithmetic.
   bsa_pkg::dp_cmd_type cmd;
   bsa_pkg::dp_sts_type sts;
   bsa_pkg::vec_type    amount;

   assign amount = {req_amount_3, req_amount_2, req_amount_1, req_amount_0};

   bsa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   bsa_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_kind       (req_kind),
      .req_process_id (req_process_id),
      .req_amount     (amount),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status)
   );

`ifndef SYNTH
   // An accepted transaction always makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted transaction did not start");
   // Results are never back to back.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe repeated");
   // A result strobe always follows a busy cycle.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without a transaction");
   // Status codes stay within the defined range.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= bsa_pkg::STS_OVER_RELEASE)
      else $error("undefined status code");
`endif

endmodule

### tb/sv/tb_bankers_safety_allocator.sv
// Self-checking testbench for bankers_safety_allocator: directed table, then random phases.
// Depends on bsa_pkg and the allocator RTL; a built-in predictor tracks claims and grants.
`timescale 1ns / 100ps

module tb_bankers_safety_allocator;

   localparam int ITEMS_PER_PHASE = 135;
   localparam int PHASES          = 10;
   localparam int CYCLE_LIMIT     = 1_500_000;
   localparam int DRAIN_CYCLES    = 80;
   localparam int NR              = bsa_pkg::RESOURCES;
   localparam int NP              = bsa_pkg::MAX_PROCESSES;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [2:0] req_kind;
   logic [2:0] req_process_id;
   logic [7:0] req_amount_0;
   logic [7:0] req_amount_1;
   logic [7:0] req_amount_2;
   logic [7:0] req_amount_3;
   logic       rsp_valid;
   logic [2:0] rsp_status;
   logic       csr_we;
   logic [2:0] csr_index;
   logic [7:0] csr_wdata;

   bankers_safety_allocator DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_process_id(req_process_id),
      .req_amount_0(req_amount_0), .req_amount_1(req_amount_1),
      .req_amount_2(req_amount_2), .req_amount_3(req_amount_3),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // One line of the directed table. A row either writes a register or sends a
   // transaction; known_status marks rows whose answer is typed in by hand.
   typedef struct packed {
      logic                 is_csr;
      logic [2:0]           csr_idx;
      logic [7:0]           csr_val;
      logic [2:0]           kind;
      logic [2:0]           pid;
      bsa_pkg::vec_type     amount;
      logic                 known_status;
      bsa_pkg::status_type  status;
   } stim_row_type;

   // Shadow copy of the allocator's tables and registers.
   int unsigned shadow_pcount;
   int unsigned shadow_total [NR];
   int unsigned shadow_claim [NP][NR];
   int unsigned shadow_alloc [NP][NR];
   int unsigned shadow_free  [NR];

   bsa_pkg::status_type pending_status [$];
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  idle_percent;
   stim_row_type        stim_table [$];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Append one row to the directed table.
   function automatic void table_add(stim_row_type row);
      stim_table = {stim_table, row};
   endfunction

   // Clamp the process count register the way the block does: zero means one,
   // anything above the table size means the table size.
   function automatic int unsigned active_processes();
      if (shadow_pcount == 0) return 1;
      if (shadow_pcount > NP) return NP;
      return shadow_pcount;
   endfunction

   // Apply a register write to the shadow state. A new total recomputes the free
   // pool from what is already handed out, floored at zero.
   function automatic void shadow_csr_write(logic [2:0] idx, logic [7:0] val);
      int unsigned used;
      int          r;
      if (idx == bsa_pkg::CSR_PROCESS_COUNT) begin
         shadow_pcount = 32'(val[3:0]);
      end else if (idx >= bsa_pkg::CSR_TOTAL_BASE && idx < bsa_pkg::CSR_TOTAL_BASE + NR) begin
         r = 32'(idx - bsa_pkg::CSR_TOTAL_BASE);
         shadow_total[r] = 32'(val);
         used = 0;
         for (int p = 0; p < NP; p++) used += shadow_alloc[p][r];
         shadow_free[r] = (val > used) ? val - used : 0;
      end
   endfunction

   // Banker's safety test with the request tentatively granted to process q:
   // repeatedly retire any process whose remaining need fits the work vector.
   function automatic bit grant_is_safe(int q, bsa_pkg::vec_type amt, int unsigned n);
      int unsigned work [NR];
      bit          done [NP];
      int unsigned finished;
      int unsigned held;
      int unsigned need;
      bit          progress;
      bit          fits;
      finished = 0;
      for (int r = 0; r < NR; r++) work[r] = shadow_free[r] - amt[r];
      for (int p = 0; p < NP; p++) done[p] = 1'b0;
      progress = 1'b1;
      while (progress) begin
         progress = 1'b0;
         for (int p = 0; p < n; p++) begin
            if (!done[p]) begin
               fits = 1'b1;
               for (int r = 0; r < NR; r++) begin
                  held = shadow_alloc[p][r] + ((p == q) ? amt[r] : 0);
                  need = (shadow_claim[p][r] > held) ? shadow_claim[p][r] - held : 0;
                  if (need > work[r]) fits = 1'b0;
               end
               if (fits) begin
                  for (int r = 0; r < NR; r++)
                     work[r] += shadow_alloc[p][r] + ((p == q) ? amt[r] : 0);
                  done[p]  = 1'b1;
                  finished++;
                  progress = 1'b1;
               end
            end
         end
      end
      return finished == n;
   endfunction

   // Work out the answer to one accepted transaction and update the shadow tables.
   function automatic bsa_pkg::status_type allocate_step(logic [2:0] kind, logic [2:0] pid,
                                                         bsa_pkg::vec_type amt);
      bsa_pkg::status_type sts;
      int unsigned         n;
      int unsigned         need;
      int unsigned         sum;
      sts = bsa_pkg::STS_APPROVED;
      n   = active_processes();
      if (pid >= n) return bsa_pkg::STS_APPROVED;
      case (kind)
         bsa_pkg::KIND_CLAIM: begin
            for (int r = 0; r < NR; r++)
               if (amt[r] > shadow_total[r] || amt[r] < shadow_alloc[pid][r])
                  sts = bsa_pkg::STS_OVER_CLAIM;
            if (sts == bsa_pkg::STS_APPROVED)
               for (int r = 0; r < NR; r++) shadow_claim[pid][r] = 32'(amt[r]);
         end
         bsa_pkg::KIND_REQUEST: begin
            for (int r = 0; r < NR; r++) begin
               need = (shadow_claim[pid][r] > shadow_alloc[pid][r])
                    ? shadow_claim[pid][r] - shadow_alloc[pid][r] : 0;
               if (amt[r] > need) sts = bsa_pkg::STS_OVER_CLAIM;
            end
            if (sts == bsa_pkg::STS_APPROVED)
               for (int r = 0; r < NR; r++)
                  if (amt[r] > shadow_free[r]) sts = bsa_pkg::STS_WAIT;
            if (sts == bsa_pkg::STS_APPROVED) begin
               if (grant_is_safe(32'(pid), amt, n)) begin
                  for (int r = 0; r < NR; r++) begin
                     shadow_alloc[pid][r] += amt[r];
                     shadow_free[r]       -= amt[r];
                  end
               end else begin
                  sts = bsa_pkg::STS_UNSAFE;
               end
            end
         end
         bsa_pkg::KIND_RELEASE: begin
            for (int r = 0; r < NR; r++)
               if (amt[r] > shadow_alloc[pid][r]) sts = bsa_pkg::STS_OVER_RELEASE;
            if (sts == bsa_pkg::STS_APPROVED)
               for (int r = 0; r < NR; r++) begin
                  shadow_alloc[pid][r] -= amt[r];
                  sum = shadow_free[r] + amt[r];
                  shadow_free[r] = (sum > 255) ? 255 : sum;
               end
         end
         bsa_pkg::KIND_RELEASE_ALL: begin
            for (int r = 0; r < NR; r++) begin
               sum = shadow_free[r] + shadow_alloc[pid][r];
               shadow_free[r] = (sum > 255) ? 255 : sum;
               shadow_alloc[pid][r] = 0;
            end
         end
         default: sts = bsa_pkg::STS_APPROVED;   // no-op and the unused kinds
      endcase
      return sts;
   endfunction

   // Results cannot be held off, so every strobe is checked against the oldest
   // pending expectation on the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_status.size() == 0) begin
            $error("rsp_status: unexpected transaction, actual %0d", rsp_status);
            error_count++;
         end else begin
            if (rsp_status !== pending_status[0]) begin
               $error("rsp_status: expected %0d, actual %0d",
                      pending_status[0], rsp_status);
               error_count++;
            end
            void'(pending_status.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_bankers_safety_allocator: done, errors");
         $finish;
      end
   end

   // Present one transaction and hold it until the edge that accepts it. Start is
   // left high; the idle gap that may follow lowers it.
   task automatic send_item(logic [2:0] kind, logic [2:0] pid, bsa_pkg::vec_type amt,
                            logic known, bsa_pkg::status_type typed);
      bsa_pkg::status_type predicted;
      bsa_pkg::status_type expected;
      start          <= 1'b1;
      req_kind       <= kind;
      req_process_id <= pid;
      req_amount_0   <= amt[0];
      req_amount_1   <= amt[1];
      req_amount_2   <= amt[2];
      req_amount_3   <= amt[3];
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = allocate_step(kind, pid, amt);
      if (known) expected = typed;
      else       expected = predicted;
      pending_status = {pending_status, expected};
      if (idle_percent != 0 && $urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_percent) @(posedge clock);
      end
   endtask

   // Register writes only happen with nothing in flight.
   task automatic write_csr(logic [2:0] idx, logic [7:0] val);
      start <= 1'b0;
      @(posedge clock);
      while (busy || pending_status.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      shadow_csr_write(idx, val);
      csr_we    <= 1'b0;
   endtask

   function automatic stim_row_type item_row(bsa_pkg::kind_type kind, int pid, int a0,
                                             int a1, int a2, int a3, logic known,
                                             bsa_pkg::status_type sts);
      stim_row_type row;
      row              = '0;
      row.kind         = kind;
      row.pid          = 3'(pid);
      row.amount       = {8'(a3), 8'(a2), 8'(a1), 8'(a0)};
      row.known_status = known;
      row.status       = sts;
      return row;
   endfunction

   function automatic stim_row_type csr_row(logic [2:0] idx, int val);
      stim_row_type row;
      row         = '0;
      row.is_csr  = 1'b1;
      row.csr_idx = idx;
      row.csr_val = 8'(val);
      return row;
   endfunction

   // Draw one random transaction. Most are well formed against the shadow state so
   // that grants pile up and the safety check has real work; the rest are noise.
   task automatic send_random_item();
      int               pick;
      int unsigned      n;
      int unsigned      lo;
      int unsigned      hi;
      logic [2:0]       kind;
      logic [2:0]       pid;
      bsa_pkg::vec_type amt;
      n    = active_processes();
      pid  = ($urandom_range(99) < 90) ? 3'($urandom_range(n - 1)) : 3'($urandom_range(7));
      pick = $urandom_range(99);
      if (pick < 12)      kind = bsa_pkg::KIND_CLAIM;
      else if (pick < 57) kind = bsa_pkg::KIND_REQUEST;
      else if (pick < 82) kind = bsa_pkg::KIND_RELEASE;
      else if (pick < 91) kind = bsa_pkg::KIND_RELEASE_ALL;
      else if (pick < 95) kind = bsa_pkg::KIND_NOP;
      else                kind = 3'($urandom_range(5, 7));
      for (int r = 0; r < NR; r++) begin
         amt[r] = 8'($urandom_range(255));
         if ($urandom_range(99) < 85) begin
            case (kind)
               bsa_pkg::KIND_CLAIM: begin
                  lo = shadow_alloc[pid][r];
                  hi = shadow_total[r];
                  if (hi >= lo) amt[r] = 8'($urandom_range(hi, lo));
               end
               bsa_pkg::KIND_REQUEST: begin
                  hi = (shadow_claim[pid][r] > shadow_alloc[pid][r])
                     ? shadow_claim[pid][r] - shadow_alloc[pid][r] : 0;
                  amt[r] = ($urandom_range(3) == 0) ? 8'(hi) : 8'($urandom_range(hi));
               end
               bsa_pkg::KIND_RELEASE: amt[r] = 8'($urandom_range(shadow_alloc[pid][r]));
               default: ;
            endcase
         end
      end
      send_item(kind, pid, amt, 1'b0, bsa_pkg::STS_APPROVED);
   endtask

   initial begin
      int pcount_plan [PHASES] = '{8, 1, 3, 0, 15, 5, 2, 8, 4, 6};
      int tval;
      idle_percent   = 0;
      reset          = 1'b1;
      start          = 1'b0;
      req_kind       = '0;
      req_process_id = '0;
      req_amount_0   = '0;
      req_amount_1   = '0;
      req_amount_2   = '0;
      req_amount_3   = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      shadow_pcount  = 8;
      for (int r = 0; r < NR; r++) begin
         shadow_total[r] = 0;
         shadow_free[r]  = 0;
         for (int p = 0; p < NP; p++) begin
            shadow_claim[p][r] = 0;
            shadow_alloc[p][r] = 0;
         end
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset every total is zero, so any nonzero claim is over the total
      // and any nonzero request exceeds the claim, any nonzero release what the process holds.
      table_add(item_row(bsa_pkg::KIND_NOP, 0, 0, 0, 0, 0, 1, bsa_pkg::STS_APPROVED));
      table_add(item_row(bsa_pkg::kind_type'(3'd5), 7, 255, 255, 255, 255, 1,
                         bsa_pkg::STS_APPROVED));
      table_add(item_row(bsa_pkg::kind_type'(3'd7), 2, 0, 0, 0, 0, 1,
                         bsa_pkg::STS_APPROVED));
      table_add(item_row(bsa_pkg::KIND_CLAIM, 3, 1, 0, 0, 0, 1, bsa_pkg::STS_OVER_CLAIM));
      table_add(item_row(bsa_pkg::KIND_REQUEST, 0, 0, 0, 0, 0, 1, bsa_pkg::STS_APPROVED));
      table_add(item_row(bsa_pkg::KIND_REQUEST, 0, 1, 0, 0, 0, 1, bsa_pkg::STS_OVER_CLAIM));
      table_add(item_row(bsa_pkg::KIND_RELEASE, 2, 0, 0, 0, 1, 1,
                         bsa_pkg::STS_OVER_RELEASE));
      table_add(item_row(bsa_pkg::KIND_RELEASE_ALL, 7, 0, 0, 0, 0, 1,
                         bsa_pkg::STS_APPROVED));
      // A small three-process system; answers here come from the predictor, but for inactive processes.
      table_add(csr_row(bsa_pkg::CSR_PROCESS_COUNT, 3));
      table_add(csr_row(bsa_pkg::CSR_TOTAL_BASE, 10));
      table_add(csr_row(3'(bsa_pkg::CSR_TOTAL_BASE + 3'd1), 5));
      table_add(csr_row(3'(bsa_pkg::CSR_TOTAL_BASE + 3'd2), 7));
      table_add(csr_row(3'(bsa_pkg::CSR_TOTAL_BASE + 3'd3), 255));
      table_add(item_row(bsa_pkg::KIND_CLAIM, 0, 7, 5, 3, 0, 0, bsa_pkg::STS_APPROVED));
      table_add(item_row(bsa_pkg::KIND_CLAIM, 1, 3, 2, 2, 0, 0, bsa_pkg::STS_APPROVED));
      table_add(item_row(bsa_pkg::KIND_CLAIM, 2, 9, 0, 2, 255, 0, bsa_pkg::STS_APPROVED));
      table_add(item_row(bsa_pkg::KIND_REQUEST, 1, 2, 0, 0, 0, 0, bsa_pkg::STS_APPROVED));
      table_add(item_row(bsa_pkg::KIND_REQUEST, 0, 0, 1, 0, 0, 0, bsa_pkg::STS_APPROVED));
      table_add(item_row(bsa_pkg::KIND_REQUEST, 2, 3, 0, 2, 255, 0, bsa_pkg::STS_APPROVED));
      table_add(item_row(bsa_pkg::KIND_REQUEST, 0, 7, 4, 3, 0, 0, bsa_pkg::STS_APPROVED));
      table_add(item_row(bsa_pkg::KIND_REQUEST, 5, 255, 255, 255, 255, 1,
                         bsa_pkg::STS_APPROVED));
      table_add(item_row(bsa_pkg::KIND_RELEASE, 1, 2, 0, 0, 0, 0, bsa_pkg::STS_APPROVED));
      table_add(item_row(bsa_pkg::KIND_RELEASE_ALL, 2, 0, 0, 0, 0, 0,
                         bsa_pkg::STS_APPROVED));
      table_add(csr_row(bsa_pkg::CSR_PROCESS_COUNT, 0));
      table_add(item_row(bsa_pkg::KIND_REQUEST, 1, 1, 0, 0, 0, 1, bsa_pkg::STS_APPROVED));

      foreach (stim_table[i]) begin
         if (stim_table[i].is_csr)
            write_csr(stim_table[i].csr_idx, stim_table[i].csr_val);
         else
            send_item(stim_table[i].kind, stim_table[i].pid, stim_table[i].amount,
                      stim_table[i].known_status, stim_table[i].status);
      end

      // Random phases. Each one picks a process count (zero and above-range values
      // included) and totals with the extremes mixed in, then an idle pattern.
      for (int ph = 0; ph < PHASES; ph++) begin
         write_csr(bsa_pkg::CSR_PROCESS_COUNT, 8'(pcount_plan[ph]));
         for (int r = 0; r < NR; r++) begin
            case (ph)
               0, 7:    tval = 255;
               1:       tval = 0;
               default: tval = ($urandom_range(3) == 0) ? $urandom_range(255)
                                                       : $urandom_range(1, 24);
            endcase
            write_csr(3'(bsa_pkg::CSR_TOTAL_BASE + 3'(r)), 8'(tval));
         end
         case (ph % 3)
            0:       idle_percent = 0;
            1:       idle_percent = 86;
            default: idle_percent = 24;
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random_item();
      end

      start <= 1'b0;
      @(posedge clock);
      while (busy || pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_bankers_safety_allocator: done, clean");
      end else begin
         $display("tb_bankers_safety_allocator: done, errors");
      end
      $finish;
   end

endmodule
